// ===== rtl/clpf_ssd_pkg.sv =====
// Package for the constrained low-pass filter SSD probe.
// Holds pixel and accumulator widths, small types and the per-pixel filter functions.
// No dependencies.
`default_nettype none

package clpf_ssd_pkg;

  localparam int ROW_PIXELS = 8;
  localparam int PIX_W      = 8;
  localparam int ROW_W      = ROW_PIXELS * PIX_W;
  localparam int PAIR_W     = 2 * PIX_W;
  localparam int STR_W      = 3;
  localparam int CDIFF_W    = STR_W + 1;
  localparam int DELTA_W    = 8;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int ROW_SUM_W  = SQ_W + $clog2(ROW_PIXELS);
  localparam int ACC_W      = 22;
  localparam int EDGE       = 2;

  localparam logic [STR_W-1:0] STRENGTH_RESET = STR_W'(1);

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic signed [CDIFF_W-1:0] cdiff_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [SQ_W-1:0]           sq_t;

  // Difference of a neighbor to the center pixel, clamped to +/- strength.
  function automatic cdiff_t clamp_diff(pix_t nb, pix_t c, logic [STR_W-1:0] s);
    logic signed [PIX_W:0] d;
    logic signed [PIX_W:0] lim;
    d   = $signed({1'b0, nb}) - $signed({1'b0, c});
    lim = $signed({{(PIX_W + 1 - STR_W){1'b0}}, s});
    if (d > lim) begin
      clamp_diff = cdiff_t'(lim);
    end else if (d < -lim) begin
      clamp_diff = cdiff_t'(-lim);
    end else begin
      clamp_diff = cdiff_t'(d);
    end
  endfunction

  function automatic delta_t ext(cdiff_t x);
    ext = delta_t'(x);
  endfunction

  // Weighted sum of the six clamped differences, rounded offset, and the
  // filtered pixel taken modulo 256.
  function automatic pix_t filter_pix(pix_t c, cdiff_t a, cdiff_t b, cdiff_t l1,
                                      cdiff_t r1, cdiff_t l2, cdiff_t r2);
    delta_t vert;
    delta_t near;
    delta_t delta;
    delta_t t;
    delta_t off;
    vert  = ext(a) + ext(b);
    near  = ext(l1) + ext(r1);
    delta = (vert <<< 2) + (near <<< 1) + near + ext(l2) + ext(r2);
    t     = delta + delta_t'(8) - delta_t'(delta[DELTA_W-1]);
    off   = t >>> 4;
    filter_pix = c + pix_t'(off);
  endfunction

  function automatic pix_t abs_diff(pix_t a, pix_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/clpf_block_ssd_detect.sv =====
// Top level of the constrained low-pass filter SSD probe: filter, squares and block sums.
// Depends on clpf_ssd_pkg.
`default_nettype none

// One beat is one 8-pixel row of an 8x8 block with its neighbors and edge flags.
// A row is accepted every cycle while in_stall_o is low. The pipeline has four row
// registers: input, pixel differences, squares and row sums; the block sums then
// update in the accumulator and pass to the result register on a last row. Only a
// last-row beat that reaches the accumulator while the previous result is still held
// stalls the pipeline; other rows keep flowing. The user must write the filter strength
// over the config port while no row is in flight; the block does not check. Resets to 1.
module clpf_block_ssd_detect (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [clpf_ssd_pkg::STR_W-1:0]    cfg_filter_strength_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [clpf_ssd_pkg::ROW_W-1:0]    orig_row_i,
  input  wire logic [clpf_ssd_pkg::ROW_W-1:0]    cur_row_i,
  input  wire logic [clpf_ssd_pkg::ROW_W-1:0]    above_row_i,
  input  wire logic [clpf_ssd_pkg::ROW_W-1:0]    below_row_i,
  input  wire logic [clpf_ssd_pkg::PAIR_W-1:0]   left_pair_i,
  input  wire logic [clpf_ssd_pkg::PAIR_W-1:0]   right_pair_i,
  input  wire logic                              at_left_edge_i,
  input  wire logic                              at_right_edge_i,
  input  wire logic                              at_top_edge_i,
  input  wire logic                              at_bottom_edge_i,
  input  wire logic                              last_row_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [clpf_ssd_pkg::ACC_W-1:0]         ssd_unfiltered_o,
  output logic [clpf_ssd_pkg::ACC_W-1:0]         ssd_filtered_o
);
  import clpf_ssd_pkg::*;

  // Configuration.
  logic [STR_W-1:0] strength_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= STRENGTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      strength_q <= cfg_filter_strength_i;
    end
  end

  // Pipeline flow control.
  logic v1_q, v2_q, v3_q, v4_q;
  logic last1_q, last2_q, last3_q, last4_q;
  logic rdy1, rdy2, rdy3, rdy4, consume4;
  logic out_valid_q;

  assign consume4   = v4_q && (!last4_q || !out_valid_q || !out_stall_i);
  assign rdy4       = !v4_q || consume4;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // Stage 1: input register.
  logic [ROW_W-1:0]  orig1_q, cur1_q, above1_q, below1_q;
  logic [PAIR_W-1:0] left1_q, right1_q;
  logic              ledge1_q, redge1_q, tedge1_q, bedge1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      orig1_q  <= orig_row_i;
      cur1_q   <= cur_row_i;
      above1_q <= above_row_i;
      below1_q <= below_row_i;
      left1_q  <= left_pair_i;
      right1_q <= right_pair_i;
      ledge1_q <= at_left_edge_i;
      redge1_q <= at_right_edge_i;
      tedge1_q <= at_top_edge_i;
      bedge1_q <= at_bottom_edge_i;
      last1_q  <= last_row_i;
    end
  end

  // Stage 2: edge replacement, filter and absolute differences to the original.
  pix_t nb_pix [ROW_PIXELS + 2*EDGE];
  pix_t up_pix [ROW_PIXELS];
  pix_t dn_pix [ROW_PIXELS];
  pix_t du_d   [ROW_PIXELS];
  pix_t df_d   [ROW_PIXELS];
  pix_t du2_q  [ROW_PIXELS];
  pix_t df2_q  [ROW_PIXELS];

  always_comb begin
    pix_t c;
    pix_t o;
    pix_t f;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      nb_pix[i + EDGE] = cur1_q[i*PIX_W +: PIX_W];
      up_pix[i] = tedge1_q ? cur1_q[i*PIX_W +: PIX_W] : above1_q[i*PIX_W +: PIX_W];
      dn_pix[i] = bedge1_q ? cur1_q[i*PIX_W +: PIX_W] : below1_q[i*PIX_W +: PIX_W];
    end
    nb_pix[0] = ledge1_q ? cur1_q[0 +: PIX_W] : left1_q[0 +: PIX_W];
    nb_pix[1] = ledge1_q ? cur1_q[0 +: PIX_W] : left1_q[PIX_W +: PIX_W];
    nb_pix[ROW_PIXELS + EDGE] =
        redge1_q ? cur1_q[(ROW_PIXELS-1)*PIX_W +: PIX_W] : right1_q[0 +: PIX_W];
    nb_pix[ROW_PIXELS + EDGE + 1] =
        redge1_q ? cur1_q[(ROW_PIXELS-1)*PIX_W +: PIX_W] : right1_q[PIX_W +: PIX_W];
    for (int i = 0; i < ROW_PIXELS; i++) begin
      c = nb_pix[i + EDGE];
      o = orig1_q[i*PIX_W +: PIX_W];
      f = filter_pix(c,
                     clamp_diff(up_pix[i], c, strength_q),
                     clamp_diff(dn_pix[i], c, strength_q),
                     clamp_diff(nb_pix[i + 1], c, strength_q),
                     clamp_diff(nb_pix[i + 3], c, strength_q),
                     clamp_diff(nb_pix[i], c, strength_q),
                     clamp_diff(nb_pix[i + 4], c, strength_q));
      du_d[i] = abs_diff(o, c);
      df_d[i] = abs_diff(o, f);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      du2_q   <= du_d;
      df2_q   <= df_d;
      last2_q <= last1_q;
    end
  end

  // Stage 3: squares.
  sq_t squ3_q [ROW_PIXELS];
  sq_t sqf3_q [ROW_PIXELS];

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      for (int i = 0; i < ROW_PIXELS; i++) begin
        squ3_q[i] <= du2_q[i] * du2_q[i];
        sqf3_q[i] <= df2_q[i] * df2_q[i];
      end
      last3_q <= last2_q;
    end
  end

  // Stage 4: row sums.
  logic [ROW_SUM_W-1:0] rsu_d, rsf_d, rsu4_q, rsf4_q;

  always_comb begin
    rsu_d = '0;
    rsf_d = '0;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      rsu_d = rsu_d + ROW_SUM_W'(squ3_q[i]);
      rsf_d = rsf_d + ROW_SUM_W'(sqf3_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      rsu4_q  <= rsu_d;
      rsf4_q  <= rsf_d;
      last4_q <= last3_q;
    end
  end

  // Saturating block accumulators and the result register.
  logic [ACC_W-1:0] acc_u_q, acc_f_q, sat_u, sat_f;
  logic [ACC_W:0]   sum_u, sum_f;
  logic [ACC_W-1:0] res_u_q, res_f_q;

  assign sum_u = {1'b0, acc_u_q} + (ACC_W+1)'(rsu4_q);
  assign sum_f = {1'b0, acc_f_q} + (ACC_W+1)'(rsf4_q);
  assign sat_u = sum_u[ACC_W] ? '1 : sum_u[ACC_W-1:0];
  assign sat_f = sum_f[ACC_W] ? '1 : sum_f[ACC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_u_q     <= '0;
      acc_f_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && out_stall_i) || (consume4 && last4_q);
      if (consume4) begin
        acc_u_q <= last4_q ? '0 : sat_u;
        acc_f_q <= last4_q ? '0 : sat_f;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume4 && last4_q) begin
      res_u_q <= sat_u;
      res_f_q <= sat_f;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ssd_unfiltered_o = res_u_q;
  assign ssd_filtered_o   = res_f_q;

  // A result only ever appears because a last-row beat reached the accumulator.
  a_result_from_last_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(consume4 && last4_q))
    else $error("result raised without a last-row beat");

  // Both accumulators restart from zero after a block is closed.
  a_acc_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume4 && last4_q) |=> (acc_u_q == '0 && acc_f_q == '0))
    else $error("accumulators not cleared after last row");

  // A held input beat that cannot advance must hold off the sender.
  a_input_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && !consume4) |-> in_stall_o)
    else $error("input accepted while the pipeline is full and blocked");

endmodule

`default_nettype wire
